// ----- rtl/sfed_pkg.sv -----
// ---------------------------------------------------------------------------
// sfed_pkg: shared types and constants for the serial frame end detector
// Holds the field widths, frame-layout constants and command codes.
// ---------------------------------------------------------------------------
package sfed_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 9;
  localparam int unsigned TicksW = 8;

  // Byte positions of the captured header fields
  localparam logic [PosW-1:0] PosCode = 9'd1;
  localparam logic [PosW-1:0] PosLen  = 9'd6;

  // Frame-length rules
  localparam logic [ByteW-1:0] FnMultiWrite = 8'd16;
  localparam logic [PosW-1:0]  MinFrameLast = 9'd7;
  localparam logic [PosW-1:0]  LenOverhead  = 9'd8;

  // Idle tick limit after reset
  localparam logic [TicksW-1:0] LimitReset = 8'd40;

  // Input beat kinds
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

endpackage

// ----- rtl/sfed_in_if.sv -----
// ---------------------------------------------------------------------------
// sfed_in_if: input channel of the serial frame end detector
// Carries one received byte or one timer tick per beat.
// ---------------------------------------------------------------------------
interface sfed_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ----- rtl/sfed_out_if.sv -----
// ---------------------------------------------------------------------------
// sfed_out_if: result channel of the serial frame end detector
// Carries the echoed byte, its position and the frame end / abort flags.
// ---------------------------------------------------------------------------
interface sfed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [8:0] byte_position;
  logic       byte_valid;
  logic       frame_end;
  logic [8:0] frame_length;
  logic       timeout_abort;

  modport source (output valid, output byte_value, output byte_position,
                  output byte_valid, output frame_end, output frame_length,
                  output timeout_abort, input ready);
  modport sink   (input valid, input byte_value, input byte_position,
                  input byte_valid, input frame_end, input frame_length,
                  input timeout_abort, output ready);
endinterface

// ----- rtl/serial_frame_end_detector.sv -----
// The result beat for an accepted input beat is registered and appears in the cycle after it is accepted.
// Throughput: one beat per cycle; the result register drains while the next
// beat is accepted, so only a stalled result holds off input.
// Reset: synchronous, active low; clears the position count, idle timer,
// result valid and loads the idle tick limit with its default of 40.
// ---------------------------------------------------------------------------
// serial_frame_end_detector: frame boundary tracker for a serial byte stream
// Tags each byte with its frame position, detects frame ends from the
// function code and length header, and drops partial frames on idle timeout.
// ---------------------------------------------------------------------------
module serial_frame_end_detector
  import sfed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  sfed_in_if.sink     in_ch,
  sfed_out_if.source  out_ch
);

  // Frame state
  logic [PosW-1:0]   byte_count_r, byte_count_nxt;
  logic [ByteW-1:0]  function_code_r, function_code_nxt;
  logic [ByteW-1:0]  length_field_r, length_field_nxt;
  logic              timer_running_r, timer_running_nxt;
  logic [TicksW-1:0] idle_ticks_r, idle_ticks_nxt;
  logic [TicksW-1:0] limit_r;

  // Result register
  logic              out_valid_r;
  logic [ByteW-1:0]  byte_value_r, byte_value_nxt;
  logic [PosW-1:0]   byte_position_r, byte_position_nxt;
  logic              byte_valid_r, byte_valid_nxt;
  logic              frame_end_r, frame_end_nxt;
  logic [PosW-1:0]   frame_length_r, frame_length_nxt;
  logic              timeout_abort_r, timeout_abort_nxt;

  logic              in_accept;
  logic [PosW-1:0]   count_inc;
  logic [PosW-1:0]   len_end;
  logic [TicksW:0]   ticks_inc;
  logic              ended;

  // Accept whenever the result slot is empty or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign count_inc = byte_count_r + 9'd1;
  assign len_end   = {1'b0, length_field_r} + LenOverhead;
  assign ticks_inc = {1'b0, idle_ticks_r} + 9'd1;

  // Frame end: long frame for multi-write, fixed length otherwise
  always_comb begin
    ended = 1'b0;
    if (count_inc > MinFrameLast) begin
      if (function_code_r == FnMultiWrite) begin
        ended = (count_inc > len_end);
      end else begin
        ended = 1'b1;
      end
    end
  end

  // Next state and result for one beat
  always_comb begin
    byte_count_nxt    = byte_count_r;
    function_code_nxt = function_code_r;
    length_field_nxt  = length_field_r;
    timer_running_nxt = timer_running_r;
    idle_ticks_nxt    = idle_ticks_r;
    byte_value_nxt    = '0;
    byte_position_nxt = '0;
    byte_valid_nxt    = 1'b0;
    frame_end_nxt     = 1'b0;
    frame_length_nxt  = '0;
    timeout_abort_nxt = 1'b0;
    case (cmd_t'(in_ch.cmd))
      CMD_TICK: begin
        // Count idle ticks, drop the partial frame past the limit
        if (timer_running_r) begin
          if (ticks_inc > {1'b0, limit_r}) begin
            idle_ticks_nxt    = '0;
            timer_running_nxt = 1'b0;
            byte_count_nxt    = '0;
            timeout_abort_nxt = 1'b1;
          end else begin
            idle_ticks_nxt = ticks_inc[TicksW-1:0];
          end
        end
      end
      CMD_BYTE: begin
        // Echo the byte, capture header fields, advance the position
        timer_running_nxt = 1'b1;
        if (byte_count_r == PosCode) begin
          function_code_nxt = in_ch.rx_byte;
        end
        if (byte_count_r == PosLen) begin
          length_field_nxt = in_ch.rx_byte;
        end
        byte_count_nxt    = count_inc;
        byte_value_nxt    = in_ch.rx_byte;
        byte_position_nxt = byte_count_r;
        byte_valid_nxt    = 1'b1;
        if (ended) begin
          frame_end_nxt     = 1'b1;
          frame_length_nxt  = count_inc;
          byte_count_nxt    = '0;
          timer_running_nxt = 1'b0;
          idle_ticks_nxt    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      timer_running_r <= 1'b0;
      idle_ticks_r    <= '0;
      limit_r         <= LimitReset;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (in_accept) begin
        byte_count_r    <= byte_count_nxt;
        timer_running_r <= timer_running_nxt;
        idle_ticks_r    <= idle_ticks_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Header fields and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      function_code_r <= function_code_nxt;
      length_field_r  <= length_field_nxt;
      byte_value_r    <= byte_value_nxt;
      byte_position_r <= byte_position_nxt;
      byte_valid_r    <= byte_valid_nxt;
      frame_end_r     <= frame_end_nxt;
      frame_length_r  <= frame_length_nxt;
      timeout_abort_r <= timeout_abort_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_value    = byte_value_r;
  assign out_ch.byte_position = byte_position_r;
  assign out_ch.byte_valid    = byte_valid_r;
  assign out_ch.frame_end     = frame_end_r;
  assign out_ch.frame_length  = frame_length_r;
  assign out_ch.timeout_abort = timeout_abort_r;

  // Position count never reaches the longest frame length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r < 9'd264)
    else $error("byte count out of range");

  // A frame end leaves the position count cleared
  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (ended && in_ch.cmd == CMD_BYTE)) |=> byte_count_r == '0)
    else $error("count not cleared after frame end");

  // An abort only comes from a tick, a frame end only from a byte
  a_flag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(timeout_abort_r && byte_valid_r) &&
                    !(frame_end_r && !byte_valid_r))
    else $error("flag on wrong beat kind");

  // Frame length is reported exactly with a frame end
  a_len_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (frame_end_r == (frame_length_r != '0)))
    else $error("frame length without frame end");

  // Idle timer stays at zero while no frame is in progress
  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    !timer_running_r |-> idle_ticks_r == '0)
    else $error("idle ticks counted while timer stopped");

endmodule

// ----- test/sfed_checker.sv -----
// ---------------------------------------------------------------------------
// sfed_checker: beat checker for the serial frame end detector
// Watches both channels and the config port, tracks the frame position,
// header bytes and idle timer on its own, and compares every result beat
// field by field against the oldest predicted one.
// ---------------------------------------------------------------------------
module sfed_checker
  import sfed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  sfed_in_if         in_ch,
  sfed_out_if        out_ch,
  output int         beats_in_flight,
  output int         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic [PosW-1:0]  byte_position;
    logic             byte_valid;
    logic             frame_end;
    logic [PosW-1:0]  frame_length;
    logic             timeout_abort;
  } tag_t;

  // Shadow frame state
  logic [PosW-1:0]   pos_count;
  logic [ByteW-1:0]  fn_code;
  logic [ByteW-1:0]  len_code;
  logic              timer_on;
  logic [TicksW-1:0] tick_count;
  logic [TicksW-1:0] tick_limit;

  tag_t tagged_beats_q[$];

  // Advance the shadow state by one input beat and return its tagged result
  function automatic tag_t track_frame_beat(cmd_t cmd, logic [ByteW-1:0] rx);
    tag_t            t;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] count;
    logic [PosW-1:0] next_ticks;
    logic            done;
    t = '0;
    if (cmd == CMD_TICK) begin
      // Count only while a frame is open; the 9-bit sum never wraps
      if (timer_on) begin
        next_ticks = {1'b0, tick_count} + 9'd1;
        if (next_ticks > {1'b0, tick_limit}) begin
          tick_count      = '0;
          timer_on        = 1'b0;
          pos_count       = '0;
          t.timeout_abort = 1'b1;
        end else begin
          tick_count = next_ticks[TicksW-1:0];
        end
      end
      return t;
    end
    pos      = pos_count;
    count    = pos + 9'd1;
    timer_on = 1'b1;
    if (pos == PosCode) fn_code = rx;
    if (pos == PosLen) len_code = rx;
    pos_count = count;
    done = 1'b0;
    if (count > MinFrameLast) begin
      done = (fn_code != FnMultiWrite) || (count > ({1'b0, len_code} + LenOverhead));
    end
    t.byte_value    = rx;
    t.byte_position = pos;
    t.byte_valid    = 1'b1;
    if (done) begin
      t.frame_end    = 1'b1;
      t.frame_length = count;
      pos_count      = '0;
      timer_on       = 1'b0;
      tick_count     = '0;
    end
    return t;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare result beats first, then queue the prediction for the new input beat
  always @(posedge clk) begin
    tag_t want;
    if (!rst_n) begin
      pos_count  = '0;
      fn_code    = '0;
      len_code   = '0;
      timer_on   = 1'b0;
      tick_count = '0;
      tick_limit = LimitReset;
      tagged_beats_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tagged_beats_q.size() == 0) begin
          $error("result beat with no input beat outstanding");
          fail_count++;
        end else begin
          want = tagged_beats_q.pop_front();
          check_field("byte_value", 32'(want.byte_value), 32'(out_ch.byte_value));
          check_field("byte_position", 32'(want.byte_position),
                      32'(out_ch.byte_position));
          check_field("byte_valid", 32'(want.byte_valid), 32'(out_ch.byte_valid));
          check_field("frame_end", 32'(want.frame_end), 32'(out_ch.frame_end));
          check_field("frame_length", 32'(want.frame_length),
                      32'(out_ch.frame_length));
          check_field("timeout_abort", 32'(want.timeout_abort),
                      32'(out_ch.timeout_abort));
        end
      end
      if (cfg_we) tick_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        tagged_beats_q.push_back(track_frame_beat(cmd_t'(in_ch.cmd), in_ch.rx_byte));
      end
    end
    beats_in_flight = tagged_beats_q.size();
  end

endmodule

// ----- test/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: top level for the serial frame end detector
// Drives directed frames, aborts and limit corner cases, then random phases
// of well-formed, truncated and noisy byte/tick streams under several
// limit settings and idle patterns; the checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench
  import sfed_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         beats_in_flight;
  int         fail_count;
  int         sender_idle_pct;
  int         recv_stall_pct;
  int         limit_now;
  int         items_sent;

  sfed_in_if  in_bus ();
  sfed_out_if out_bus ();

  serial_frame_end_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  sfed_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_ch           (in_bus),
    .out_ch          (out_bus),
    .beats_in_flight (beats_in_flight),
    .fail_count      (fail_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stall the result side at the current rate
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one beat, idling first at the current rate, and hold until taken
  task automatic send_beat(cmd_t c, logic [7:0] b);
    logic took;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.cmd     <= c;
    in_bus.rx_byte <= b;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_bus.ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_beat(CMD_TICK, 8'($urandom_range(255)));
  endtask

  // Drop valid and hold until every predicted result beat has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (beats_in_flight != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(int v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= 8'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = v;
  endtask

  // Send one frame with random content; a truncated one is left to time out
  task automatic send_frame();
    logic [7:0] fc;
    logic [7:0] len;
    logic [7:0] b;
    int         total;
    int         cut;
    int         ticks_used;
    int         k;
    logic       broken;
    fc  = $urandom_range(1) ? FnMultiWrite : 8'($urandom_range(255));
    len = ($urandom_range(99) < 4) ? 8'($urandom_range(255, 200)) : 8'($urandom_range(24));
    total  = (fc == FnMultiWrite) ? int'(len) + 9 : 8;
    broken = ($urandom_range(99) < 15);
    cut    = broken ? $urandom_range(total - 1, 1) : total;
    ticks_used = 0;
    for (int i = 0; i < cut; i++) begin
      b = (i == PosCode) ? fc : (i == PosLen) ? len : 8'($urandom_range(255));
      send_beat(CMD_BYTE, b);
      // Sprinkle ticks while staying within the idle limit
      if ($urandom_range(99) < 10 && ticks_used < limit_now) begin
        k = $urandom_range(3, 1);
        if (k > limit_now - ticks_used) k = limit_now - ticks_used;
        send_ticks(k);
        ticks_used += k;
      end
    end
    if (broken) send_ticks(limit_now + 1 - ticks_used + $urandom_range(2));
  endtask

  initial begin
    int phase_end;
    int pick;
    int limits[6];
    in_bus.valid    <= 1'b0;
    in_bus.cmd      <= 1'b0;
    in_bus.rx_byte  <= 8'd0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 8'd0;
    rst_n           <= 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    limit_now       = LimitReset;
    items_sent      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tick while no frame is open
    send_beat(CMD_TICK, 8'h5A);
    // Plain 8-byte frame with byte extremes
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h03);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hAA);
    // Multi-write frame with zero length: ends at 9 bytes
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, FnMultiWrite);
    for (int i = 2; i < 6; i++) send_beat(CMD_BYTE, 8'($urandom_range(255)));
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'h55);
    send_beat(CMD_BYTE, 8'hC3);
    // Zero limit: first tick aborts
    write_limit(0);
    send_beat(CMD_BYTE, 8'h81);
    send_beat(CMD_TICK, 8'h00);
    // Bytes do not restart the timer: second tick aborts at limit 1
    write_limit(1);
    send_beat(CMD_BYTE, 8'h7E);
    send_beat(CMD_TICK, 8'hFF);
    send_beat(CMD_BYTE, 8'h42);
    send_beat(CMD_TICK, 8'h00);

    // Random phases over limit settings and idle patterns
    limits = '{255, 40, $urandom_range(254, 2), 1, 8, $urandom_range(255, 1)};
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      phase_end = items_sent + 215;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          send_frame();
        end else begin
          repeat ($urandom_range(6, 1)) begin
            send_beat(cmd_t'($urandom_range(1)), 8'($urandom_range(255)));
          end
        end
        if ($urandom_range(99) < 2) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && beats_in_flight == 0) begin
      $display("serial_frame_end_detector: match");
    end else begin
      $display("serial_frame_end_detector: mismatch");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #1_000_000;
    $display("serial_frame_end_detector: mismatch");
    $finish;
  end

endmodule
